// ===== src/mpid_pkg.sv =====
// shared types, constants and codes for the multivariable pid controller
// no dependencies; every other file imports this package
package mpid_pkg;

    localparam int JOINTS     = 4;
    localparam int MAX_JOINTS = 4;

    localparam int POS_W   = 12;
    localparam int ERR_W   = 13;
    localparam int DERR_W  = 14;
    localparam int GAIN_W  = 32;
    localparam int SUM_W   = 32;
    localparam int DT_W    = 16;
    localparam int DRIVE_W = 32;
    localparam int IDX_W   = 2;
    localparam int P_W     = 48;
    localparam int A_W     = 64;
    localparam int D_W     = 48;

    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 128;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    localparam logic [IDX_W-1:0] JLAST = IDX_W'(JOINTS - 1);

    // request kinds
    typedef enum logic [1:0] {
        KIND_GAIN = 2'd0,
        KIND_SETP = 2'd1,
        KIND_MEAS = 2'd2
    } kind_t;

    // gain matrix select
    localparam logic [1:0] MTX_P = 2'd0;
    localparam logic [1:0] MTX_I = 2'd1;
    localparam logic [1:0] MTX_D = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_DT    = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_FLOOR = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_CEIL  = 2'd2;

    localparam logic [DT_W-1:0]  DT_RST     = 16'd655;
    localparam logic [POS_W-1:0] FLOOR_RST  = 12'd0;
    localparam logic [POS_W-1:0] CEIL_RST   = 12'd4095;
    localparam logic [POS_W-1:0] TARGET_RST = 12'd2048;

    localparam logic signed [A_W-1:0] GAIN_CLAMP = 64'sh1000_0000_0000_0000;
    localparam logic signed [46:0]    ACC_CLAMP  = 47'sh2000_0000_0000;
    // half of 100 * 2^16, rounding offset
    localparam logic [65:0]           ROUND_HALF = 66'd3276800;
    // quotient reaches 2^31 from here
    localparam logic [49:0]           SAT_Y      = 50'd214748364800;
    // ceil(2^45 / 100), exact floor divide for values below 2^38
    localparam logic [38:0]           DIV_MUL    = 39'd351843720889;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic                     en;
        logic [1:0]               mtx;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [GAIN_W-1:0] value;
    } gain_wr_t;

    typedef struct packed {
        logic                     vld;
        logic                     first;
        logic                     last;
        logic [IDX_W-1:0]         col;
        logic signed [ERR_W-1:0]  e;
        logic signed [SUM_W-1:0]  s;
        logic signed [DERR_W-1:0] de;
    } col_t;

    typedef struct packed {
        gain_wr_t wr;
        col_t     c;
        logic     take;
    } lane_ctl_t;

    typedef struct packed {
        logic                      vld;
        logic signed [DRIVE_W-1:0] drive;
    } lane_sts_t;

endpackage

// ===== src/mpid_fin.sv =====
// finishing pipeline of one lane: dt scaling, rounding divide by 6553600, saturation
// depends on mpid_pkg
module mpid_fin (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mpid_pkg::DT_W-1:0]     dt,
    input  logic                          in_vld,
    input  logic signed [mpid_pkg::P_W-1:0] p_in,
    input  logic signed [mpid_pkg::A_W-1:0] a_in,
    input  logic signed [mpid_pkg::D_W-1:0] d_in,
    input  logic                          take,
    output mpid_pkg::lane_sts_t           sts
);
    import mpid_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic res_vld_reg;
    logic signed [DRIVE_W-1:0] res_reg;

    logic signed [46:0] a_c;
    logic signed [16:0] dt_s;
    logic signed [47:0] ah_reg;
    logic [31:0]        al_reg;
    logic signed [48:0] dh_reg;
    logic [31:0]        dl_reg;
    logic signed [P_W-1:0] p1_reg;

    logic signed [65:0] p_x, ah_x, dh_x, lo_x, t_c;
    logic signed [65:0] t_reg;

    logic [65:0] mag, rnd;
    logic [49:0] y_c;
    logic [37:0] y_reg;
    logic        neg3_reg, sat3_reg, neg4_reg, sat4_reg;

    logic [37:0] hh_reg, lh_reg;
    logic [38:0] hl_reg, ll_reg;
    logic [77:0] prod;
    logic [30:0] q;
    logic signed [DRIVE_W-1:0] drive_c;

    // integral sum window
    always_comb begin
        if (a_in > A_W'(ACC_CLAMP))
            a_c = ACC_CLAMP;
        else if (a_in < -A_W'(ACC_CLAMP))
            a_c = -ACC_CLAMP;
        else
            a_c = a_in[46:0];
    end

    assign dt_s = $signed({1'b0, dt});

    always_ff @(posedge aclk) begin
        ah_reg <= $signed(a_c[46:16]) * dt_s;
        al_reg <= a_c[15:0] * dt;
        dh_reg <= $signed(d_in[47:16]) * dt_s;
        dl_reg <= d_in[15:0] * dt;
        p1_reg <= p_in;
    end

    always_comb begin
        p_x  = p1_reg;
        ah_x = ah_reg;
        dh_x = dh_reg;
        lo_x = $signed({34'd0, al_reg}) + $signed({34'd0, dl_reg});
        t_c  = (p_x <<< 16) + ((ah_x + dh_x) <<< 16) + lo_x;
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_c;
    end

    always_comb begin
        mag = t_reg[65] ? 66'(-t_reg) : 66'(t_reg);
        rnd = mag + ROUND_HALF;
        y_c = rnd[65:16];
    end

    always_ff @(posedge aclk) begin
        y_reg    <= y_c[37:0];
        neg3_reg <= t_reg[65];
        sat3_reg <= (y_c >= SAT_Y);
    end

    // partial products of the reciprocal multiply
    always_ff @(posedge aclk) begin
        hh_reg   <= y_reg[37:19] * DIV_MUL[38:20];
        hl_reg   <= y_reg[37:19] * DIV_MUL[19:0];
        lh_reg   <= y_reg[18:0]  * DIV_MUL[38:20];
        ll_reg   <= y_reg[18:0]  * DIV_MUL[19:0];
        neg4_reg <= neg3_reg;
        sat4_reg <= sat3_reg;
    end

    always_comb begin
        prod = (78'(hh_reg) << 39) + (78'(hl_reg) << 19) + (78'(lh_reg) << 20)
             + 78'(ll_reg);
        q = prod[75:45];
        if (sat4_reg)
            drive_c = neg4_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg4_reg)
            drive_c = -$signed({1'b0, q});
        else
            drive_c = $signed({1'b0, q});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (v4_reg)
                res_vld_reg <= 1'b1;
            else if (take)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg)
            res_reg <= drive_c;
    end

    assign sts.vld   = res_vld_reg;
    assign sts.drive = res_reg;

endmodule

// ===== src/mpid_lane.sv =====
// one output joint lane: its gain rows and a multiply-accumulate over the columns
// depends on mpid_pkg and mpid_fin
module mpid_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [mpid_pkg::IDX_W-1:0] lane_row,
    input  logic [mpid_pkg::DT_W-1:0]  dt,
    input  mpid_pkg::lane_ctl_t        ctl,
    output mpid_pkg::lane_sts_t        sts
);
    import mpid_pkg::*;

    logic signed [GAIN_W-1:0] kp_reg [MAX_JOINTS];
    logic signed [GAIN_W-1:0] ki_reg [MAX_JOINTS];
    logic signed [GAIN_W-1:0] kd_reg [MAX_JOINTS];

    logic signed [44:0]  pp_reg;
    logic signed [63:0]  pi_reg;
    logic signed [45:0]  pd_reg;
    logic                m_vld_reg, m_first_reg, m_last_reg;

    logic signed [A_W-1:0] pi_c;
    logic signed [P_W-1:0] p_acc_reg, p_acc_next;
    logic signed [A_W-1:0] a_acc_reg, a_acc_next;
    logic signed [D_W-1:0] d_acc_reg, d_acc_next;
    logic                  acc_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_JOINTS; k++) begin
                kp_reg[k] <= '0;
                ki_reg[k] <= '0;
                kd_reg[k] <= '0;
            end
        end else if (ctl.wr.en && ctl.wr.row == lane_row) begin
            case (ctl.wr.mtx)
                MTX_P:   kp_reg[ctl.wr.col] <= ctl.wr.value;
                MTX_I:   ki_reg[ctl.wr.col] <= ctl.wr.value;
                MTX_D:   kd_reg[ctl.wr.col] <= ctl.wr.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg      <= kp_reg[ctl.c.col] * ctl.c.e;
        pi_reg      <= ki_reg[ctl.c.col] * ctl.c.s;
        pd_reg      <= kd_reg[ctl.c.col] * ctl.c.de;
        m_first_reg <= ctl.c.first;
        m_last_reg  <= ctl.c.last;
    end

    always_comb begin
        if (pi_reg > GAIN_CLAMP)
            pi_c = GAIN_CLAMP;
        else if (pi_reg < -GAIN_CLAMP)
            pi_c = -GAIN_CLAMP;
        else
            pi_c = pi_reg;
        p_acc_next = (m_first_reg ? P_W'(0) : p_acc_reg) + pp_reg;
        a_acc_next = (m_first_reg ? A_W'(0) : a_acc_reg) + pi_c;
        d_acc_next = (m_first_reg ? D_W'(0) : d_acc_reg) + pd_reg;
    end

    always_ff @(posedge aclk) begin
        if (m_vld_reg) begin
            p_acc_reg <= p_acc_next;
            a_acc_reg <= a_acc_next;
            d_acc_reg <= d_acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg   <= 1'b0;
            acc_vld_reg <= 1'b0;
        end else begin
            m_vld_reg   <= ctl.c.vld;
            acc_vld_reg <= m_vld_reg && m_last_reg;
        end
    end

    mpid_fin u_fin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dt      (dt),
        .in_vld  (acc_vld_reg),
        .p_in    (p_acc_reg),
        .a_in    (a_acc_reg),
        .d_in    (d_acc_reg),
        .take    (ctl.take),
        .sts     (sts)
    );

endmodule

// ===== src/multivariable_pid_controller_core.sv =====
// four-joint pid controller with full 4x4 p, i and d gain matrices
// depends on mpid_pkg and mpid_lane (which holds mpid_fin)
// a measurement request gives its result after the column walk of the lanes and the
//   finishing pipeline; gain and setpoint requests give no result
// no new request is taken while a measurement is in flight; the next request is taken
//   once the result is registered in the output register
// reset: synchronous active-low aresetn clears gains, sums and last errors,
//   setpoints go to 2048 and the configuration registers to their defaults
module multivariable_pid_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value_a, value_b, value_c, value_d, which_matrix, gain_row, gain_col, gain_value, pad
    input  logic [mpid_pkg::S_DATA_W-1:0]   s_tdata,
    // kind
    input  logic [mpid_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // drive_a, drive_b, drive_c, drive_d
    output logic [mpid_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [mpid_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [mpid_pkg::CFG_D_W-1:0]    cfg_wdata
);
    import mpid_pkg::*;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    // configuration
    logic [DT_W-1:0]  dt_reg;
    logic [POS_W-1:0] floor_reg, ceil_reg;

    // per joint state
    logic [POS_W-1:0]         target_reg [MAX_JOINTS];
    logic signed [SUM_W-1:0]  sum_reg    [MAX_JOINTS];
    logic signed [ERR_W-1:0]  last_reg   [MAX_JOINTS];

    // operands of the request in flight
    logic signed [ERR_W-1:0]  e_reg  [MAX_JOINTS];
    logic signed [SUM_W-1:0]  s_reg  [MAX_JOINTS];
    logic signed [DERR_W-1:0] de_reg [MAX_JOINTS];

    logic signed [ERR_W-1:0]  e_c    [MAX_JOINTS];
    logic signed [SUM_W-1:0]  s_c    [MAX_JOINTS];
    logic signed [DERR_W-1:0] de_c   [MAX_JOINTS];
    logic [POS_W-1:0]         tgt_c  [MAX_JOINTS];
    logic signed [SUM_W:0]    sum_x;

    logic [POS_W-1:0] vals [MAX_JOINTS];
    logic             s_acc;
    logic             take;

    lane_ctl_t ctl;
    lane_sts_t sts [MAX_JOINTS];

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]    m_tdata_reg;

    // unpack the request
    assign vals[0] = s_tdata[11:0];
    assign vals[1] = s_tdata[23:12];
    assign vals[2] = s_tdata[35:24];
    assign vals[3] = s_tdata[47:36];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // result leaves the lanes when the output register is free
    assign take = (state_reg == ST_WAIT) && sts[0].vld && (!m_tvalid_reg || m_tready);

    // gain write broadcast to all lanes, each picks its own row
    assign ctl.wr.en    = s_acc && (s_tuser == KIND_GAIN);
    assign ctl.wr.mtx   = s_tdata[49:48];
    assign ctl.wr.row   = s_tdata[51:50];
    assign ctl.wr.col   = s_tdata[53:52];
    assign ctl.wr.value = $signed(s_tdata[85:54]);

    // column walk shared by all lanes
    assign ctl.c.vld   = (state_reg == ST_RUN);
    assign ctl.c.first = (cnt_reg == '0);
    assign ctl.c.last  = (cnt_reg == JLAST);
    assign ctl.c.col   = cnt_reg;
    assign ctl.c.e     = e_reg[cnt_reg];
    assign ctl.c.s     = s_reg[cnt_reg];
    assign ctl.c.de    = de_reg[cnt_reg];
    assign ctl.take    = take;

    // per joint error, saturated sum, difference and clamped setpoint
    always_comb begin
        for (int j = 0; j < MAX_JOINTS; j++) begin
            e_c[j]  = $signed({1'b0, target_reg[j]}) - $signed({1'b0, vals[j]});
            sum_x   = (SUM_W+1)'(sum_reg[j]) + (SUM_W+1)'(e_c[j]);
            if (sum_x[SUM_W] != sum_x[SUM_W-1])
                s_c[j] = sum_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
            else
                s_c[j] = sum_x[SUM_W-1:0];
            de_c[j] = DERR_W'(e_c[j]) - DERR_W'(last_reg[j]);
            if (vals[j] < floor_reg)
                tgt_c[j] = floor_reg;
            else if (vals[j] > ceil_reg)
                tgt_c[j] = ceil_reg;
            else
                tgt_c[j] = vals[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_JOINTS; j++) begin
                target_reg[j] <= TARGET_RST;
                sum_reg[j]    <= '0;
                last_reg[j]   <= '0;
            end
        end else if (s_acc) begin
            for (int j = 0; j < JOINTS; j++) begin
                if (s_tuser == KIND_SETP)
                    target_reg[j] <= tgt_c[j];
                if (s_tuser == KIND_MEAS) begin
                    sum_reg[j]  <= s_c[j];
                    last_reg[j] <= e_c[j];
                end
            end
        end
    end

    // operands held for the column walk
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == KIND_MEAS) begin
            for (int j = 0; j < MAX_JOINTS; j++) begin
                e_reg[j]  <= e_c[j];
                s_reg[j]  <= s_c[j];
                de_reg[j] <= de_c[j];
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg    <= DT_RST;
            floor_reg <= FLOOR_RST;
            ceil_reg  <= CEIL_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DT:    dt_reg    <= cfg_wdata;
                CFG_FLOOR: floor_reg <= cfg_wdata[POS_W-1:0];
                CFG_CEIL:  ceil_reg  <= cfg_wdata[POS_W-1:0];
                default:   ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_acc && s_tuser == KIND_MEAS)
                    state_next = ST_RUN;
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == JLAST)
                    state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (take)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // one lane per driven joint
    for (genvar gi = 0; gi < MAX_JOINTS; gi++) begin : g_lane
        if (gi < JOINTS) begin : g_on
            mpid_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .lane_row (IDX_W'(gi)),
                .dt       (dt_reg),
                .ctl      (ctl),
                .sts      (sts[gi])
            );
        end else begin : g_off
            assign sts[gi] = '0;
        end
    end

    // merge the lane results into one output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (take)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (take)
            m_tdata_reg <= {sts[3].drive, sts[2].drive, sts[1].drive, sts[0].drive};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/mpid_checker.sv =====
// port-level checks for the pid controller core, attached by bind
// depends on mpid_pkg and multivariable_pid_controller_core
module mpid_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mpid_pkg::S_USER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import mpid_pkg::*;

    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result visible after reset");

    // a measurement occupies the lanes
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_MEAS |=> !s_tready)
        else $error("request taken while lanes busy");

    // state-only requests never produce a result
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != KIND_MEAS && !m_tvalid |=> !m_tvalid)
        else $error("result from a non-measurement request");

endmodule

bind multivariable_pid_controller_core mpid_checker u_mpid_checker (.*);
